@@ rtl/rerc_pkg.sv @@
package rerc_pkg;

  // Default model geometry.
  localparam int DEF_SPLIT_CONTEXTS = 16;
  localparam int DEF_CHANNELS       = 4;
  localparam int DEF_MAG_CONTEXTS   = 8;
  localparam int DEF_PROB_BITS      = 11;
  localparam int DEF_MOVE_BITS      = 5;

  // The neighbor bucket count is fixed by the context helper upstream.
  localparam int PREV_CONTEXTS = 7;
  localparam int ESC_BITS      = 7;
  localparam int FLUSH_SHIFTS  = 5;

  localparam logic [31:0] RANGE_TOP    = 32'h0100_0000;
  localparam logic [31:0] RANGE_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] LOW_FF_LIMIT = 32'hFF00_0000;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [7:0]  FILL_NO_CARRY = 8'hFF;
  localparam logic [7:0]  FILL_CARRY    = 8'h00;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic       kind;
    logic       neg;
    logic [7:0] mag;
    logic [3:0] area_bucket;
    logic [1:0] chan;
    logic [2:0] nbr_bucket;
  } job_t;

endpackage

@@ rtl/rerc_ifs.sv @@
interface rerc_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [7:0] residual;
  logic [3:0]        area_bucket;
  logic [1:0]        chan;
  logic [2:0]        nbr_bucket;

  modport source (output valid, kind, residual, area_bucket, chan, nbr_bucket, input ready);
  modport sink (input valid, kind, residual, area_bucket, chan, nbr_bucket, output ready);
endinterface

interface rerc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  lead_byte;
  logic [7:0]  fill_byte;
  logic [31:0] fill_count;
  logic        last;

  modport source (output valid, lead_byte, fill_byte, fill_count, last, input ready);
  modport sink (input valid, lead_byte, fill_byte, fill_count, last, output ready);
endinterface

@@ rtl/rerc_front.sv @@
module rerc_front #(
  parameter int SPLIT_CONTEXTS = rerc_pkg::DEF_SPLIT_CONTEXTS,
  parameter int CHANNELS       = rerc_pkg::DEF_CHANNELS
) (
  input  logic            clk,
  input  logic            rst_n,
  rerc_in_if.sink         in_bus,
  output logic            job_valid,
  input  logic            job_ready,
  output rerc_pkg::job_t  job
);
  import rerc_pkg::*;

  logic  v_r;
  job_t  job_r;
  job_t  cls;
  logic  accept;

  assign in_bus.ready = !v_r || job_ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // Saturate the context buckets and split the residual into sign and magnitude.
  always_comb begin
    cls.kind = in_bus.kind;
    cls.neg  = in_bus.residual[7];
    cls.mag  = in_bus.residual[7] ? 8'(-in_bus.residual) : 8'(in_bus.residual);
    cls.area_bucket = (int'(in_bus.area_bucket) >= SPLIT_CONTEXTS) ?
                      4'(SPLIT_CONTEXTS - 1) : in_bus.area_bucket;
    cls.chan = (int'(in_bus.chan) >= CHANNELS) ? 2'(CHANNELS - 1) : in_bus.chan;
    cls.nbr_bucket = (int'(in_bus.nbr_bucket) >= PREV_CONTEXTS) ?
                     3'(PREV_CONTEXTS - 1) : in_bus.nbr_bucket;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (job_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= cls;
    end
  end

  assign job_valid = v_r;
  assign job       = job_r;

endmodule

@@ rtl/rerc_queue.sv @@
module rerc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  rerc_pkg::job_t  push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rerc_pkg::job_t  pop_job
);
  import rerc_pkg::*;

  localparam int DEPTH = 2;

  job_t       slot_r [DEPTH];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/rerc_back.sv @@
module rerc_back #(
  parameter int SPLIT_CONTEXTS = rerc_pkg::DEF_SPLIT_CONTEXTS,
  parameter int CHANNELS       = rerc_pkg::DEF_CHANNELS,
  parameter int MAG_CONTEXTS   = rerc_pkg::DEF_MAG_CONTEXTS,
  parameter int PROB_BITS      = rerc_pkg::DEF_PROB_BITS,
  parameter int MOVE_BITS      = rerc_pkg::DEF_MOVE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  rerc_pkg::job_t  job,
  rerc_out_if.source      out_bus
);
  import rerc_pkg::*;

  localparam int SIGN_DEPTH = SPLIT_CONTEXTS * CHANNELS;
  localparam int SIG_DEPTH  = SIGN_DEPTH * PREV_CONTEXTS;
  localparam int MAG_DEPTH  = SIG_DEPTH * MAG_CONTEXTS;
  localparam int SIGN_AW    = (SIGN_DEPTH > 1) ? $clog2(SIGN_DEPTH) : 1;
  localparam int SIG_AW     = $clog2(SIG_DEPTH);
  localparam int MAG_AW     = $clog2(MAG_DEPTH);
  localparam int MC_W       = (MAG_CONTEXTS > 1) ? $clog2(MAG_CONTEXTS) : 1;

  localparam logic [PROB_BITS-1:0] PROB_INIT = PROB_BITS'(1 << (PROB_BITS - 1));
  localparam logic [PROB_BITS:0]   PROB_ONE  = (PROB_BITS + 1)'(1 << PROB_BITS);
  localparam logic [6:0]           MC_ESC    = 7'(MAG_CONTEXTS);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_UPD   = 4'd4;
  localparam logic [3:0] ST_FLAT  = 4'd5;
  localparam logic [3:0] ST_NORM  = 4'd6;
  localparam logic [3:0] ST_FLUSH = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam logic [1:0] DEC_SIG  = 2'd0;
  localparam logic [1:0] DEC_SIGN = 2'd1;
  localparam logic [1:0] DEC_MAG  = 2'd2;
  localparam logic [1:0] DEC_FLAT = 2'd3;

  // Probability models.
  logic [PROB_BITS-1:0] sig_mem  [SIG_DEPTH];
  logic [PROB_BITS-1:0] sign_mem [SIGN_DEPTH];
  logic [PROB_BITS-1:0] mag_mem  [MAG_DEPTH];
  logic [PROB_BITS-1:0] sig_rd_r, sign_rd_r, mag_rd_r;

  logic [3:0]          state_r, state_nxt;
  logic [1:0]          dec_r, dec_nxt;
  logic [MC_W-1:0]     mi_r, mi_nxt;
  logic [2:0]          fb_r, fb_nxt;
  logic                done_r, done_nxt;
  logic [2:0]          fl_cnt_r, fl_cnt_nxt;
  logic [MAG_AW-1:0]   clr_r, clr_nxt;

  logic                neg_r, neg_nxt;
  logic                nz_r, nz_nxt;
  logic [6:0]          rem_r, rem_nxt;
  logic [6:0]          esc_r, esc_nxt;
  logic [SIGN_AW-1:0]  sc_r, sc_nxt;
  logic [SIG_AW-1:0]   sig_idx_r, sig_idx_nxt;
  logic [MAG_AW-1:0]   mag_addr_r, mag_addr_nxt;

  logic [32:0]         low_r, low_nxt;
  logic [31:0]         range_r, range_nxt;
  logic [7:0]          pbyte_r, pbyte_nxt;
  logic [31:0]         pcount_r, pcount_nxt;
  logic [31:0]         bound_r, bound_nxt;

  logic                hold_v_r, hold_v_nxt;
  logic [7:0]          hold_lead_r, hold_lead_nxt;
  logic [7:0]          hold_fill_r, hold_fill_nxt;
  logic [31:0]         hold_cnt_r, hold_cnt_nxt;

  logic                out_v_r;
  logic [7:0]          out_lead_r, out_fill_r;
  logic [31:0]         out_cnt_r;
  logic                out_last_r;

  logic                push;
  logic                push_last;
  logic                out_free;

  logic [PROB_BITS-1:0] prob_sel;
  logic [PROB_BITS-1:0] prob_new;
  logic [PROB_BITS:0]   prob_gap;
  logic                 bit_sel;
  logic [31-PROB_BITS:0] rng_hi;

  logic                sig_we, sign_we, mag_we;
  logic [SIG_AW-1:0]   sig_wa;
  logic [SIGN_AW-1:0]  sign_wa;
  logic [MAG_AW-1:0]   mag_wa;
  logic [PROB_BITS-1:0] wdata;

  logic [SIGN_AW-1:0]  ld_sc;
  logic [SIG_AW-1:0]   ld_sig;
  logic [6:0]          ld_rem;

  logic [31:0]         sh_low32;
  logic                sh_carry;
  logic                sh_emit;
  logic                sh_stall;
  logic                sh_go;
  logic [31:0]         sh_base;

  assign out_free = !out_v_r || out_bus.ready;

  // Model indexes of the item at the head of the queue.
  assign ld_sc  = SIGN_AW'(int'(job.area_bucket) * CHANNELS + int'(job.chan));
  assign ld_sig = SIG_AW'(int'(ld_sc) * PREV_CONTEXTS + int'(job.nbr_bucket));
  assign ld_rem = 7'(job.mag - 8'd1);

  always_comb begin
    case (dec_r)
      DEC_SIG:  prob_sel = sig_rd_r;
      DEC_SIGN: prob_sel = sign_rd_r;
      default:  prob_sel = mag_rd_r;
    endcase
    case (dec_r)
      DEC_SIG:  bit_sel = nz_r;
      DEC_SIGN: bit_sel = neg_r;
      DEC_MAG:  bit_sel = (rem_r > 7'(mi_r));
      default:  bit_sel = 1'b0;
    endcase
  end

  assign rng_hi   = range_r[31:PROB_BITS];
  assign prob_gap = PROB_ONE - {1'b0, prob_sel};
  assign prob_new = bit_sel ? (prob_sel - (prob_sel >> MOVE_BITS))
                            : PROB_BITS'({1'b0, prob_sel} + (prob_gap >> MOVE_BITS));

  // One byte shift of the low register; a released run goes to the hold stage.
  assign sh_low32 = low_r[31:0];
  assign sh_carry = low_r[32];
  assign sh_emit  = sh_carry || (sh_low32 < LOW_FF_LIMIT);
  assign sh_stall = sh_emit && hold_v_r && !out_free;
  assign sh_go    = ((state_r == ST_NORM) || (state_r == ST_FLUSH)) && !sh_stall;
  assign sh_base  = sh_emit ? 32'd0 : pcount_r;

  always_comb begin
    state_nxt     = state_r;
    dec_nxt       = dec_r;
    mi_nxt        = mi_r;
    fb_nxt        = fb_r;
    done_nxt      = done_r;
    fl_cnt_nxt    = fl_cnt_r;
    clr_nxt       = clr_r;
    neg_nxt       = neg_r;
    nz_nxt        = nz_r;
    rem_nxt       = rem_r;
    esc_nxt       = esc_r;
    sc_nxt        = sc_r;
    sig_idx_nxt   = sig_idx_r;
    mag_addr_nxt  = mag_addr_r;
    low_nxt       = low_r;
    range_nxt     = range_r;
    pbyte_nxt     = pbyte_r;
    pcount_nxt    = pcount_r;
    bound_nxt     = bound_r;
    hold_v_nxt    = hold_v_r;
    hold_lead_nxt = hold_lead_r;
    hold_fill_nxt = hold_fill_r;
    hold_cnt_nxt  = hold_cnt_r;
    push          = 1'b0;
    push_last     = 1'b0;
    job_ready     = 1'b0;
    sig_we        = 1'b0;
    sign_we       = 1'b0;
    mag_we        = 1'b0;
    sig_wa        = sig_idx_r;
    sign_wa       = sc_r;
    mag_wa        = mag_addr_r;
    wdata         = prob_new;

    if (sh_go) begin
      if (sh_emit) begin
        push          = hold_v_r;
        hold_v_nxt    = 1'b1;
        hold_lead_nxt = pbyte_r + {7'd0, sh_carry};
        hold_fill_nxt = sh_carry ? FILL_CARRY : FILL_NO_CARRY;
        hold_cnt_nxt  = pcount_r - 32'd1;
        pbyte_nxt     = sh_low32[31:24];
      end
      pcount_nxt = (sh_base == COUNT_MAX) ? sh_base : sh_base + 32'd1;
      low_nxt    = {1'b0, sh_low32[23:0], 8'h00};
    end

    case (state_r)
      ST_CLR: begin
        wdata   = PROB_INIT;
        sig_we  = (int'(clr_r) < SIG_DEPTH);
        sign_we = (int'(clr_r) < SIGN_DEPTH);
        mag_we  = 1'b1;
        sig_wa  = SIG_AW'(clr_r);
        sign_wa = SIGN_AW'(clr_r);
        mag_wa  = clr_r;
        clr_nxt = clr_r + MAG_AW'(1);
        if (clr_r == MAG_AW'(MAG_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          job_ready    = 1'b1;
          neg_nxt      = job.neg;
          nz_nxt       = (job.mag != 8'd0);
          rem_nxt      = ld_rem;
          esc_nxt      = ld_rem - MC_ESC;
          sc_nxt       = ld_sc;
          sig_idx_nxt  = ld_sig;
          mag_addr_nxt = MAG_AW'(int'(ld_sig) * MAG_CONTEXTS);
          dec_nxt      = DEC_SIG;
          mi_nxt       = '0;
          fb_nxt       = 3'(ESC_BITS - 1);
          done_nxt     = 1'b0;
          fl_cnt_nxt   = 3'd0;
          state_nxt    = job.kind ? ST_FLUSH : ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        bound_nxt = 32'(rng_hi) * 32'(prob_sel);
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (bit_sel) begin
          low_nxt   = low_r + {1'b0, bound_r};
          range_nxt = range_r - bound_r;
        end else begin
          range_nxt = bound_r;
        end
        sig_we  = (dec_r == DEC_SIG);
        sign_we = (dec_r == DEC_SIGN);
        mag_we  = (dec_r == DEC_MAG);
        case (dec_r)
          DEC_SIG: begin
            if (bit_sel) begin
              dec_nxt = DEC_SIGN;
            end else begin
              done_nxt = 1'b1;
            end
          end
          DEC_SIGN: begin
            dec_nxt = DEC_MAG;
          end
          default: begin
            if (!bit_sel) begin
              done_nxt = 1'b1;
            end else if (mi_r == MC_W'(MAG_CONTEXTS - 1)) begin
              dec_nxt = DEC_FLAT;
            end else begin
              mi_nxt       = mi_r + MC_W'(1);
              mag_addr_nxt = mag_addr_r + MAG_AW'(1);
            end
          end
        endcase
        if (range_nxt < RANGE_TOP) begin
          state_nxt = ST_NORM;
        end else if (done_nxt) begin
          state_nxt = ST_FIN;
        end else if (dec_nxt == DEC_FLAT) begin
          state_nxt = ST_FLAT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_FLAT: begin
        range_nxt = {1'b0, range_r[31:1]};
        if (esc_r[fb_r]) begin
          low_nxt = low_r + {2'b00, range_r[31:1]};
        end
        if (fb_r == 3'd0) begin
          done_nxt = 1'b1;
        end else begin
          fb_nxt = fb_r - 3'd1;
        end
        if (range_nxt < RANGE_TOP) begin
          state_nxt = ST_NORM;
        end else if (done_nxt) begin
          state_nxt = ST_FIN;
        end
      end
      ST_NORM: begin
        if (sh_go) begin
          range_nxt = {range_r[23:0], 8'h00};
          if (range_nxt >= RANGE_TOP) begin
            if (done_r) begin
              state_nxt = ST_FIN;
            end else if (dec_r == DEC_FLAT) begin
              state_nxt = ST_FLAT;
            end else begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (sh_go) begin
          fl_cnt_nxt = fl_cnt_r + 3'd1;
          if (fl_cnt_r == 3'(FLUSH_SHIFTS - 1)) begin
            // The coder returns to its start values; the models are kept.
            low_nxt    = '0;
            range_nxt  = RANGE_INIT;
            pbyte_nxt  = 8'd0;
            pcount_nxt = 32'd1;
            state_nxt  = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      low_r    <= '0;
      range_r  <= RANGE_INIT;
      pbyte_r  <= 8'd0;
      pcount_r <= 32'd1;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      low_r    <= low_nxt;
      range_r  <= range_nxt;
      pbyte_r  <= pbyte_nxt;
      pcount_r <= pcount_nxt;
      hold_v_r <= hold_v_nxt;
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dec_r       <= dec_nxt;
    mi_r        <= mi_nxt;
    fb_r        <= fb_nxt;
    done_r      <= done_nxt;
    fl_cnt_r    <= fl_cnt_nxt;
    neg_r       <= neg_nxt;
    nz_r        <= nz_nxt;
    rem_r       <= rem_nxt;
    esc_r       <= esc_nxt;
    sc_r        <= sc_nxt;
    sig_idx_r   <= sig_idx_nxt;
    mag_addr_r  <= mag_addr_nxt;
    bound_r     <= bound_nxt;
    hold_lead_r <= hold_lead_nxt;
    hold_fill_r <= hold_fill_nxt;
    hold_cnt_r  <= hold_cnt_nxt;
    if (push) begin
      out_lead_r <= hold_lead_r;
      out_fill_r <= hold_fill_r;
      out_cnt_r  <= hold_cnt_r;
      out_last_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (sig_we) begin
      sig_mem[sig_wa] <= wdata;
    end
    sig_rd_r <= sig_mem[sig_idx_r];
  end

  always_ff @(posedge clk) begin
    if (sign_we) begin
      sign_mem[sign_wa] <= wdata;
    end
    sign_rd_r <= sign_mem[sc_r];
  end

  always_ff @(posedge clk) begin
    if (mag_we) begin
      mag_mem[mag_wa] <= wdata;
    end
    mag_rd_r <= mag_mem[mag_addr_r];
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.lead_byte  = out_lead_r;
  assign out_bus.fill_byte  = out_fill_r;
  assign out_bus.fill_count = out_cnt_r;
  assign out_bus.last       = out_last_r;

endmodule

@@ rtl/range_encoder_residual_coder.sv @@
// Adaptive binary range coder for signed residuals.
// in_bus carries one item per valid/ready handshake: kind 0 codes a residual
// under its split, channel and neighbor contexts, kind 1 flushes the stream.
// out_bus carries byte runs: lead_byte followed by fill_count copies of
// fill_byte; last marks the final run caused by an input item, and an item
// may cause no run at all.
// A front stage classifies items into a two-entry queue, so up to three items
// are taken while the coder is busy. The coder handles one item at a time:
// each adaptive decision steps through model read, multiply and update, each
// escape bit through a flat step, and each renormalizing byte shift through its
// own step, between a load and a finish step. The chain of dependent decisions
// through the range register sets the pace.
// After reset the probability models are swept to their initial value, one
// entry per cycle, over all SPLIT_CONTEXTS*CHANNELS*7*MAG_CONTEXTS entries (3584 by
// default); items queue in the front during that time.
// When out_bus stalls, one run waits in the output register and one more in a
// hold stage; the coder then stops at its next byte release.
module range_encoder_residual_coder #(
  parameter int SPLIT_CONTEXTS = rerc_pkg::DEF_SPLIT_CONTEXTS,
  parameter int CHANNELS       = rerc_pkg::DEF_CHANNELS,
  parameter int MAG_CONTEXTS   = rerc_pkg::DEF_MAG_CONTEXTS,
  parameter int PROB_BITS      = rerc_pkg::DEF_PROB_BITS,
  parameter int MOVE_BITS      = rerc_pkg::DEF_MOVE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  rerc_in_if.sink     in_bus,
  rerc_out_if.source  out_bus
);
  import rerc_pkg::*;

  logic fq_valid, fq_ready;
  job_t fq_job;
  logic qb_valid, qb_ready;
  job_t qb_job;

  rerc_front #(
    .SPLIT_CONTEXTS (SPLIT_CONTEXTS),
    .CHANNELS       (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  rerc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  rerc_back #(
    .SPLIT_CONTEXTS (SPLIT_CONTEXTS),
    .CHANNELS       (CHANNELS),
    .MAG_CONTEXTS   (MAG_CONTEXTS),
    .PROB_BITS      (PROB_BITS),
    .MOVE_BITS      (MOVE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_bus   (out_bus)
  );

endmodule

@@ dv/testbench.sv @@
module testbench;
  import rerc_pkg::*;

  localparam int SPLITS      = DEF_SPLIT_CONTEXTS;
  localparam int CHANS       = DEF_CHANNELS;
  localparam int MAGS        = DEF_MAG_CONTEXTS;
  localparam int PB          = DEF_PROB_BITS;
  localparam int MB          = DEF_MOVE_BITS;
  localparam int PROB_ONE    = 1 << PB;
  localparam int PROB_HALF   = 1 << (PB - 1);
  localparam int SIG_DEPTH   = SPLITS * CHANS * PREV_CONTEXTS;
  localparam int SIGN_DEPTH  = SPLITS * CHANS;
  localparam int MAG_DEPTH   = SIG_DEPTH * MAGS;
  localparam int MAX_RUNS    = 12;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN       = 200;
  localparam int MAX_REPORTS = 40;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0]  lead;
    logic [7:0]  fill;
    logic [31:0] count;
    logic        last;
  } byte_run_t;

  logic clk;
  logic rst_n;

  rerc_in_if  in_ch();
  rerc_out_if out_ch();

  range_encoder_residual_coder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch.sink),
    .out_bus (out_ch.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Encoder state mirrored in the testbench.
  logic [63:0]   enc_low;
  logic [31:0]   enc_range;
  logic [7:0]    cache_byte;
  logic [31:0]   cache_run;
  logic [PB-1:0] sig_model  [SIG_DEPTH];
  logic [PB-1:0] sign_model [SIGN_DEPTH];
  logic [PB-1:0] mag_model  [MAG_DEPTH];

  byte_run_t step_runs[$];
  byte_run_t expected_runs[$];
  byte_run_t want;

  int  errors = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;
  int  long_hold = 0;

  function automatic void reset_coder();
    enc_low    = '0;
    enc_range  = RANGE_INIT;
    cache_byte = '0;
    cache_run  = 32'd1;
  endfunction

  function automatic void reset_encoder();
    reset_coder();
    foreach (sig_model[i]) sig_model[i] = PB'(PROB_HALF);
    foreach (sign_model[i]) sign_model[i] = PB'(PROB_HALF);
    foreach (mag_model[i]) mag_model[i] = PB'(PROB_HALF);
  endfunction

  function automatic void release_byte();
    logic [31:0] low32;
    logic        carry;
    byte_run_t   run;
    low32 = enc_low[31:0];
    carry = enc_low[32];
    if (low32 < LOW_FF_LIMIT || carry) begin
      run.lead  = cache_byte + {7'b0, carry};
      run.fill  = FILL_NO_CARRY + {7'b0, carry};
      run.count = cache_run - 32'd1;
      run.last  = 1'b0;
      if (step_runs.size() < MAX_RUNS) step_runs.push_back(run);
      cache_byte = low32[31:24];
      cache_run  = '0;
    end
    if (cache_run != COUNT_MAX) cache_run = cache_run + 32'd1;
    enc_low = {32'b0, low32[23:0], 8'h00};
  endfunction

  function automatic void renormalize();
    while (enc_range < RANGE_TOP) begin
      enc_range = enc_range << 8;
      release_byte();
    end
  endfunction

  // Codes one adaptive decision and returns the adapted probability.
  function automatic logic [PB-1:0] code_decision(input logic [PB-1:0] p, input logic b);
    logic [31:0] bound;
    int          pv;
    pv    = p;
    bound = (enc_range >> PB) * 32'(p);
    if (!b) begin
      enc_range = bound;
      pv = pv + ((PROB_ONE - pv) >> MB);
    end else begin
      enc_low   = enc_low + 64'(bound);
      enc_range = enc_range - bound;
      pv = pv - (pv >> MB);
    end
    renormalize();
    return pv[PB-1:0];
  endfunction

  function automatic void code_escape(input logic [ESC_BITS-1:0] value);
    for (int k = ESC_BITS - 1; k >= 0; k--) begin
      enc_range = enc_range >> 1;
      if (value[k]) enc_low = enc_low + 64'(enc_range);
      renormalize();
    end
  endfunction

  function automatic void predict_runs(input logic kind, input logic [7:0] raw,
                                       input logic [3:0] split, input logic [1:0] ch,
                                       input logic [2:0] prev);
    logic neg;
    logic more;
    logic done;
    int   mag;
    int   rem;
    int   s;
    int   c;
    int   pc;
    int   sc;
    int   sig_idx;
    step_runs.delete();
    if (kind == KIND_FLUSH) begin
      repeat (FLUSH_SHIFTS) release_byte();
      reset_coder();
    end else begin
      neg     = raw[7];
      mag     = neg ? 256 - int'(raw) : int'(raw);
      s       = (int'(split) >= SPLITS) ? SPLITS - 1 : int'(split);
      c       = (int'(ch) >= CHANS) ? CHANS - 1 : int'(ch);
      pc      = (int'(prev) >= PREV_CONTEXTS) ? PREV_CONTEXTS - 1 : int'(prev);
      sc      = s * CHANS + c;
      sig_idx = sc * PREV_CONTEXTS + pc;
      sig_model[sig_idx] = code_decision(sig_model[sig_idx], mag != 0);
      if (mag != 0) begin
        rem  = mag - 1;
        done = 1'b0;
        sign_model[sc] = code_decision(sign_model[sc], neg);
        for (int i = 0; i < MAGS; i++) begin
          more = rem > i;
          mag_model[sig_idx * MAGS + i] = code_decision(mag_model[sig_idx * MAGS + i], more);
          if (!more) begin
            done = 1'b1;
            break;
          end
        end
        // Past the unary contexts the rest goes out as flat bits, modulo 128.
        if (!done) code_escape(ESC_BITS'(rem - MAGS));
      end
    end
    if (step_runs.size() > 0) step_runs[step_runs.size() - 1].last = 1'b1;
    foreach (step_runs[i]) expected_runs.push_back(step_runs[i]);
  endfunction

  task automatic send_item(input logic kind, input logic signed [7:0] res,
                           input logic [3:0] split, input logic [1:0] ch,
                           input logic [2:0] prev);
    int gap;
    gap = in_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.residual    <= res;
    in_ch.area_bucket <= split;
    in_ch.chan        <= ch;
    in_ch.nbr_bucket  <= prev;
    do @(posedge clk); while (!in_ch.ready);
    predict_runs(kind, res, split, ch, prev);
    items_sent++;
  endtask

  function automatic logic [7:0] draw_residual();
    int pick;
    int mag;
    pick = $urandom_range(0, 99);
    if (pick < 20) return 8'd0;
    if (pick >= 90) return 8'($urandom_range(0, 255));
    mag = (pick < 75) ? $urandom_range(1, 6) : $urandom_range(7, 20);
    return $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
  endfunction

  task automatic send_random_residual();
    send_item(KIND_CODE, draw_residual(), 4'($urandom_range(0, 15)),
              2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
  endtask

  task automatic test_directed_edges();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    // A flush straight out of reset releases only the startup bytes.
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, 8'sd0, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, 8'sd1, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, -8'sd1, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, 8'sd127, 4'd15, 2'd3, 3'd6);
    send_item(KIND_CODE, -8'sd127, 4'd15, 2'd3, 3'd6);
    send_item(KIND_CODE, -8'sd128, 4'd15, 2'd3, 3'd7);
    send_item(KIND_CODE, 8'sd8, 4'd7, 2'd1, 3'd2);
    send_item(KIND_CODE, 8'sd9, 4'd7, 2'd1, 3'd2);
    send_item(KIND_CODE, 8'sd10, 4'd7, 2'd1, 3'd2);
    send_item(KIND_CODE, -8'sd9, 4'd8, 2'd2, 3'd5);
    send_item(KIND_CODE, 8'sd0, 4'd15, 2'd3, 3'd7);
    send_item(KIND_CODE, 8'sd2, 4'd10, 2'd2, 3'd7);
    send_item(KIND_FLUSH, -8'sd1, 4'd15, 2'd3, 3'd7);
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, 8'sd0, 4'd5, 2'd2, 3'd4);
    send_item(KIND_CODE, 8'sd0, 4'd5, 2'd2, 3'd4);
    send_item(KIND_CODE, -8'sd128, 4'd0, 2'd0, 3'd0);
    send_item(KIND_CODE, 8'sd127, 4'd0, 2'd0, 3'd0);
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
  endtask

  // One context hammered with a skewed source so its models adapt, then fed large residuals.
  task automatic test_model_adaptation();
    logic [7:0] r;
    in_idle  = 1'b1;
    out_idle = 1'b1;
    for (int n = 0; n < 40; n++) begin
      r = ($urandom_range(0, 9) < 8) ? 8'd0 : 8'd1;
      if (n >= 30) r = 8'($urandom_range(100, 160));
      send_item(KIND_CODE, r, 4'd5, 2'd2, 3'd3);
    end
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
  endtask

  task automatic test_streaming();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    repeat (39) send_random_residual();
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
  endtask

  task automatic test_output_backpressure();
    in_idle   = 1'b0;
    out_idle  = 1'b1;
    long_hold = 400;
    repeat (29) send_random_residual();
    send_item(KIND_FLUSH, 8'sd0, 4'd0, 2'd0, 3'd0);
  endtask

  // Streams of residuals over a small pool of contexts, most closed by a flush,
  // with now and then a stray item from anywhere in the field ranges.
  task automatic test_random_streams();
    int         len;
    logic [3:0] split_pool [3];
    logic [1:0] ch;
    logic [2:0] prev;
    while (items_sent < 330) begin
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      len = $urandom_range(1, 30);
      ch  = 2'($urandom_range(0, 3));
      foreach (split_pool[i]) split_pool[i] = 4'($urandom_range(0, 15));
      repeat (len) begin
        if ($urandom_range(0, 19) == 0) begin
          send_random_residual();
        end else begin
          prev = 3'($urandom_range(0, 7));
          send_item(KIND_CODE, draw_residual(), split_pool[$urandom_range(0, 2)], ch, prev);
        end
      end
      if ($urandom_range(0, 9) != 0)
        send_item(KIND_FLUSH, 8'($urandom), 4'($urandom), 2'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    reset_encoder();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_CODE;
    in_ch.residual    <= '0;
    in_ch.area_bucket <= '0;
    in_ch.chan        <= '0;
    in_ch.nbr_bucket  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_model_adaptation();
    test_streaming();
    test_output_backpressure();
    test_random_streams();
    in_ch.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 8) : 0;
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_runs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte run: lead %02h fill %02h count %0d last %b",
                   $time, out_ch.lead_byte, out_ch.fill_byte, out_ch.fill_count,
                   out_ch.last);
      end else begin
        want = expected_runs.pop_front();
        if (out_ch.lead_byte !== want.lead || out_ch.fill_byte !== want.fill ||
            out_ch.fill_count !== want.count || out_ch.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: byte run mismatch: expected lead %02h fill %02h count %0d last %b, actual lead %02h fill %02h count %0d last %b",
                     $time, want.lead, want.fill, want.count, want.last,
                     out_ch.lead_byte, out_ch.fill_byte, out_ch.fill_count, out_ch.last);
        end
      end
    end
  end

  // The model sweep after reset is the longest legitimate silence.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d byte runs still expected",
                 $time, quiet_cycles, expected_runs.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
